// ===== sv/gcd_and_lcm_unit_defines.svh =====
// Assertion macros for the gcd and lcm unit.
// Included by the checker file; depends on signals named clk and rst.
`ifndef GCD_AND_LCM_UNIT_DEFINES_SVH
`define GCD_AND_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GLU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcd_and_lcm_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GLU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcd_and_lcm_unit: next-cycle check failed");

`endif

// ===== sv/glu_pkg.sv =====
// Shared types and constants for the gcd and lcm unit.
// No dependencies; used by the controller, the datapath and the top level.
package glu_pkg;

  // Number of low operand bits that take part in the computation.
  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);
  localparam int IN_W          = 32;
  localparam int GCD_W         = 32;
  localparam int LCM_W         = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_XNORM,
    ST_REDUCE,
    ST_DIVSET,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } glu_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic load_zero;
    logic pair_shift;
    logic x_shift;
    logic reduce_step;
    logic div_load;
    logic div_step;
    logic mul_load;
  } glu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_zero;
    logic both_even;
    logic x_even;
    logic y_zero;
    logic div_last;
  } glu_stat_t;

endpackage

// ===== sv/glu_ctrl.sv =====
// Controller state machine of the gcd and lcm unit.
// Depends on glu_pkg for the state, command and status types.
module glu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  glu_pkg::glu_stat_t stat,
  output glu_pkg::glu_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import glu_pkg::*;

  glu_state_t state;
  glu_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (stat.in_zero) begin
            cmd.load_zero = 1'b1;
            state_next    = ST_OUT;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_PAIR;
          end
        end
      end
      ST_PAIR: begin
        if (stat.both_even) begin
          cmd.pair_shift = 1'b1;
        end else begin
          state_next = ST_XNORM;
        end
      end
      ST_XNORM: begin
        if (stat.x_even) begin
          cmd.x_shift = 1'b1;
        end else begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (stat.y_zero) begin
          state_next = ST_DIVSET;
        end else begin
          cmd.reduce_step = 1'b1;
        end
      end
      ST_DIVSET: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_OUT);

endmodule

// ===== sv/glu_dpath.sv =====
// Datapath of the gcd and lcm unit: binary gcd registers, a restoring
// divider for a/gcd and the final multiply. Depends on glu_pkg.
module glu_dpath (
  input  logic                        clk,
  input  logic [glu_pkg::IN_W-1:0]    operand_a,
  input  logic [glu_pkg::IN_W-1:0]    operand_b,
  input  glu_pkg::glu_cmd_t           cmd,
  output glu_pkg::glu_stat_t          stat,
  output logic [glu_pkg::GCD_W-1:0]   gcd_value,
  output logic [glu_pkg::LCM_W-1:0]   lcm_value
);
  import glu_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [W-1:0]     a_m;
  logic [W-1:0]     b_m;
  logic [W-1:0]     x;
  logic [W-1:0]     y;
  logic [CNT_W-1:0] common;
  logic [W-1:0]     a_keep;
  logic [W-1:0]     b_keep;
  logic [W-1:0]     dvs;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     g_full;
  logic [W:0]       rem_sh;
  logic             rem_ge;
  logic             x_gt_y;
  logic [W-1:0]     diff;
  logic [2*W-1:0]   prod;

  // Operands reduced to the used width.
  assign a_m = operand_a[W-1:0];
  assign b_m = operand_b[W-1:0];

  // Subtractor and compare shared by the gcd reduction step.
  assign x_gt_y = (x > y);
  assign diff   = x_gt_y ? (x - y) : (y - x);

  // Gcd with the common power of two restored.
  assign g_full = x << common;

  // One restoring division step.
  assign rem_sh = {rem, quo[W-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs});

  // Quotient times the second operand gives the lcm.
  assign prod = quo * b_keep;

  // Gcd registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x      <= a_m;
      y      <= b_m;
      a_keep <= a_m;
      b_keep <= b_m;
      common <= '0;
    end else if (cmd.pair_shift) begin
      x      <= x >> 1;
      y      <= y >> 1;
      common <= common + CNT_W'(1);
    end else if (cmd.x_shift) begin
      x <= x >> 1;
    end else if (cmd.reduce_step) begin
      if (!y[0]) begin
        y <= y >> 1;
      end else begin
        if (x_gt_y) begin
          x <= y;
        end
        y <= diff;
      end
    end
  end

  // Divider registers.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvs <= g_full;
      rem <= '0;
      quo <= a_keep;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[W-1:0];
      end
      quo <= {quo[W-2:0], rem_ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.load_zero) begin
      gcd_value <= GCD_W'(a_m | b_m);
      lcm_value <= '0;
    end else begin
      if (cmd.div_load) begin
        gcd_value <= GCD_W'(g_full);
      end
      if (cmd.mul_load) begin
        lcm_value <= LCM_W'(prod);
      end
    end
  end

  // Status to the controller.
  assign stat.in_zero   = (a_m == '0) || (b_m == '0);
  assign stat.both_even = !(x[0] | y[0]);
  assign stat.x_even    = !x[0];
  assign stat.y_zero    = (y == '0);
  assign stat.div_last  = (cnt == CNT_W'(W - 1));

endmodule

// ===== sv/gcd_and_lcm_unit.sv =====
// Top level of the gcd and lcm unit: controller plus datapath.
// Depends on glu_pkg, glu_ctrl and glu_dpath.
//
//   channel   handshake           payload
//   input     start, busy         operand_a, operand_b
//   result    done (strobe)       gcd_value, lcm_value
//
// An item is taken when start is high and busy is low; busy stays high until its result
// has been shown. A zero operand goes from the accept straight to the result. Otherwise:
// load, pair shifts, odd shifts and gcd steps (each loop with an exit state), divisor
// load, 32 divider steps, multiply, result.
// Reset is synchronous and returns the unit to idle. The result is on its ports while
// done is high for exactly one cycle; the receiver cannot stall.
module gcd_and_lcm_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [glu_pkg::IN_W-1:0]  operand_a,
  input  logic [glu_pkg::IN_W-1:0]  operand_b,
  output logic                      done,
  output logic [glu_pkg::GCD_W-1:0] gcd_value,
  output logic [glu_pkg::LCM_W-1:0] lcm_value
);
  import glu_pkg::*;

  glu_cmd_t  cmd;
  glu_stat_t stat;

  // Sequencer.
  glu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Arithmetic and result registers.
  glu_dpath u_dpath (
    .clk       (clk),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .cmd       (cmd),
    .stat      (stat),
    .gcd_value (gcd_value),
    .lcm_value (lcm_value)
  );

endmodule

// ===== sv/gcd_and_lcm_unit_checker.sv =====
// Port-level checks for the gcd and lcm unit, bound to the top level.
// Depends on gcd_and_lcm_unit_defines.svh and gcd_and_lcm_unit.
`include "gcd_and_lcm_unit_defines.svh"

module gcd_and_lcm_unit_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] gcd_value,
  input logic [63:0] lcm_value
);

  // An accepted item makes the unit busy.
  `GLU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result only appears while an item is in flight.
  `GLU_ASSERT_NOW(a_done_busy, done, busy)
  // A result is shown once and then the unit is free again.
  `GLU_ASSERT_NEXT(a_done_frees, done, !done && !busy)
  // A nonzero lcm implies a nonzero gcd.
  `GLU_ASSERT_NOW(a_lcm_gcd, done && (lcm_value != 64'd0), gcd_value != 32'd0)

endmodule

bind gcd_and_lcm_unit gcd_and_lcm_unit_checker u_checker (.*);

// ===== sim/gcd_and_lcm_unit_checker.sv =====
// Scoreboard for the gcd and lcm unit: watches the item and result channels.
// Depends on glu_pkg for the operand and result widths.
module gcd_and_lcm_unit_scoreboard
  import glu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [IN_W-1:0]  operand_a,
  input  logic [IN_W-1:0]  operand_b,
  input  logic             done,
  input  logic [GCD_W-1:0] gcd_value,
  input  logic [LCM_W-1:0] lcm_value,
  output int               mismatch_count,
  output int               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [GCD_W-1:0] gcd;
    logic [LCM_W-1:0] lcm;
  } gcd_lcm_t;

  gcd_lcm_t expected_gcd_lcm[$];
  gcd_lcm_t oldest;
  int       errors = 0;

  // Euclid by remainder; for nonzero operands it agrees with the subtractive
  // and binary forms. The lcm divides first, so the product never overflows.
  function automatic gcd_lcm_t gcd_lcm_of(input logic [IN_W-1:0] raw_a,
                                          input logic [IN_W-1:0] raw_b);
    logic [GCD_W-1:0] width_mask;
    logic [GCD_W-1:0] a_used;
    logic [GCD_W-1:0] b_used;
    logic [GCD_W-1:0] x;
    logic [GCD_W-1:0] y;
    logic [GCD_W-1:0] rem;
    gcd_lcm_t         res;
    width_mask = GCD_W'((64'd1 << OPERAND_WIDTH) - 64'd1);
    a_used     = GCD_W'(raw_a) & width_mask;
    b_used     = GCD_W'(raw_b) & width_mask;
    if (a_used == '0 || b_used == '0) begin
      // A zero operand passes the other one through and has no multiple.
      res.gcd = a_used | b_used;
      res.lcm = '0;
    end else begin
      x = a_used;
      y = b_used;
      while (y != '0) begin
        rem = x % y;
        x   = y;
        y   = rem;
      end
      res.gcd = x;
      res.lcm = LCM_W'(a_used / x) * LCM_W'(b_used);
    end
    return res;
  endfunction

  // Results are retired before new items are queued; both use values from
  // just before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_gcd_lcm.size() == 0) begin
          $error("result with no item outstanding: gcd_value %0d, lcm_value %0d",
                 gcd_value, lcm_value);
          errors++;
        end else begin
          oldest = expected_gcd_lcm.pop_front();
          if (gcd_value !== oldest.gcd) begin
            $error("gcd_value: expected %0d, got %0d", oldest.gcd, gcd_value);
            errors++;
          end
          if (lcm_value !== oldest.lcm) begin
            $error("lcm_value: expected %0d, got %0d", oldest.lcm, lcm_value);
            errors++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_gcd_lcm = {expected_gcd_lcm, gcd_lcm_of(operand_a, operand_b)};
      end
    end
    mismatch_count <= errors;
    results_owed   <= expected_gcd_lcm.size();
  end

endmodule

// ===== sim/gcd_and_lcm_unit_test.sv =====
// Testbench top for the gcd and lcm unit: clock, reset, operand stimulus, verdict.
// Depends on glu_pkg, gcd_and_lcm_unit and gcd_and_lcm_unit_scoreboard.
module gcd_and_lcm_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import glu_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int EDGE_COUNT   = 20;

  // Operand pairs {a, b} at the corners of the range.
  localparam logic [63:0] EDGE_PAIRS [EDGE_COUNT] = '{
    {32'h0000_0000, 32'h0000_0000},
    {32'h0000_0000, 32'hFFFF_FFFF},
    {32'hFFFF_FFFF, 32'h0000_0000},
    {32'h0000_0000, 32'h0000_0001},
    {32'h0000_0002, 32'h0000_0000},
    {32'h0000_0001, 32'h0000_0001},
    {32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {32'hFFFF_FFFF, 32'h0000_0001},
    {32'h0000_0001, 32'hFFFF_FFFF},
    {32'hFFFF_FFFF, 32'hFFFF_FFFE},
    {32'h8000_0000, 32'h8000_0000},
    {32'h8000_0000, 32'h4000_0000},
    {32'h8000_0000, 32'h0000_0003},
    {32'hFFFF_FFFB, 32'hFFFF_FFEF},
    {32'h0000_000C, 32'h0000_0012},
    {32'h0000_0011, 32'h0000_0022},
    {32'hFFFF_0000, 32'h0000_FFFF},
    {32'hAAAA_AAAA, 32'h5555_5555},
    {32'hFFFF_FFFE, 32'h7FFF_FFFF},
    {32'hF0F0_F0F0, 32'h0F0F_0F0F}
  };

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic [IN_W-1:0]  operand_a = '0;
  logic [IN_W-1:0]  operand_b = '0;
  logic             busy;
  logic             done;
  logic [GCD_W-1:0] gcd_value;
  logic [LCM_W-1:0] lcm_value;
  int               mismatch_count;
  int               results_owed;
  int               cycle_count = 0;

  logic [IN_W-1:0]  next_a;
  logic [IN_W-1:0]  next_b;
  logic [IN_W-1:0]  factor;
  int               burst_left;
  int               kind;

  always #5 clk = ~clk;

  gcd_and_lcm_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .done      (done),
    .gcd_value (gcd_value),
    .lcm_value (lcm_value)
  );

  gcd_and_lcm_unit_scoreboard checker_i (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .done           (done),
    .gcd_value      (gcd_value),
    .lcm_value      (lcm_value),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Hard stop in case the unit hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Holds start high with the operands until the unit takes the item.
  task automatic send_operands(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
    start     <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drops start for a while and puts noise on the operand lines.
  task automatic pause_sender(input int cycles);
    start     <= 1'b0;
    operand_a <= $urandom;
    operand_b <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed corners, with an occasional short pause.
    for (int i = 0; i < EDGE_COUNT; i++) begin
      send_operands(EDGE_PAIRS[i][63:32], EDGE_PAIRS[i][31:0]);
      if (i % 3 == 2) pause_sender($urandom_range(1, 8));
    end

    // Random items in bursts; each pause lands at a random point of the
    // unit's work on the item that was just taken.
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 150));
        burst_left = $urandom_range(1, 24);
      end
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        // Wide random values, the second one of random magnitude.
        next_a = $urandom;
        next_b = $urandom >> $urandom_range(0, 31);
      end else if (kind < 55) begin
        // A shared factor, so the factor divides the gcd.
        factor = $urandom_range(1, 32'h0001_0000);
        next_a = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
        next_b = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
      end else if (kind < 65) begin
        // Odd values times powers of two exercise the common-shift path.
        next_a = ($urandom_range(1, 255) | 32'd1) << $urandom_range(0, 24);
        next_b = ($urandom_range(1, 255) | 32'd1) << $urandom_range(0, 24);
      end else if (kind < 75) begin
        // One or both operands zero.
        next_a = $urandom_range(0, 1) ? 32'd0 : $urandom;
        next_b = (next_a != 0 || $urandom_range(0, 1)) ? 32'd0 : $urandom;
      end else if (kind < 85) begin
        next_a = $urandom_range(0, 255);
        next_b = $urandom_range(0, 255);
      end else if (kind < 92) begin
        next_a = $urandom;
        next_b = next_a;
      end else begin
        // One operand a multiple of the other.
        factor = $urandom_range(1, 32'h0000_FFFF);
        next_a = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
        next_b = factor;
      end
      send_operands(next_a, next_b);
      burst_left--;
    end
    pause_sender(1);

    // Drain outstanding results, then allow for a stray late strobe.
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/glu_pkg.sv
sv/glu_ctrl.sv
sv/glu_dpath.sv
sv/gcd_and_lcm_unit.sv
sv/gcd_and_lcm_unit_checker.sv
sim/gcd_and_lcm_unit_checker.sv
sim/gcd_and_lcm_unit_test.sv
